// ----- rtl/dbcd_pkg.sv -----
// Shared types, constants and decode functions for the Danmarc2 code point decoder.
`default_nettype none

package dbcd_pkg;

   localparam int MAX_MARKS   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_AT         = 8'h40;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_CURRENCY   = 8'hA4;
   localparam logic [7:0] CHAR_AA_LOWER   = 8'hE5;
   localparam logic [7:0] CHAR_AA_UPPER   = 8'hC5;
   localparam logic [7:0] CHAR_U          = 8'h55;

   localparam logic [15:0] CP_SMALL_AA   = 16'hA733;
   localparam logic [15:0] CP_CAPITAL_AA = 16'hA732;

   localparam logic [2:0] PHASE_IDLE   = 3'd0;
   localparam logic [2:0] PHASE_FIRST  = 3'd1;
   localparam logic [2:0] PHASE_DIGITS = 3'd2;
   localparam logic [2:0] PHASE_USEQ_LAST = 3'd3;
   localparam logic [2:0] PHASE_HEX_LAST  = 3'd4;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_USEQ,
      KIND_HEX
   } esc_kind_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DRAIN
   } back_state_type;

   // One transaction from the front to the back
   typedef struct packed {
      logic        is_eos;
      logic        pending;
      logic        is_mark;
      logic [15:0] value;
   } item_type;

   // {valid, digit}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [15:0] useq_map(input logic [15:0] v);
      logic [15:0] r;
      case (v)
         16'h00A7: r = 16'h02B9;
         16'h00AE: r = 16'h02BC;
         16'h00B0: r = 16'h02BB;
         16'h00B7: r = 16'h02BA;
         16'h00D8: r = 16'h2014;
         16'h00D9: r = 16'h2191;
         16'h00DA: r = 16'h2193;
         16'h00E0: r = 16'h0309;
         16'h00EB: r = 16'hFE20;
         16'h00EC: r = 16'hFE21;
         16'h00F7: r = 16'h0326;
         16'h00F8: r = 16'h031C;
         16'h00F9: r = 16'h032E;
         16'h00FA: r = 16'hFE22;
         16'h00FC: r = 16'h0308;
         16'h00FD: r = 16'hF0FD;
         16'h00FE: r = 16'hF0FE;
         16'h00FF: r = 16'hF0FF;
         default:  r = v;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] swap_map(input logic [15:0] v);
      logic [15:0] r;
      case (v)
         16'h005E: r = 16'h0302;
         16'h005F: r = 16'h0332;
         16'h0060: r = 16'h0300;
         16'h00A8: r = 16'h0308;
         16'h00AF: r = 16'h0304;
         16'h00B4: r = 16'h0301;
         16'h00B8: r = 16'h0327;
         16'h02C7: r = 16'h030C;
         16'h02D8: r = 16'h0306;
         16'h02DA: r = 16'h030A;
         16'h02DB: r = 16'h0328;
         16'h02DD: r = 16'h030B;
         default:  r = v;
      endcase
      return r;
   endfunction

   function automatic logic is_mark(input logic [15:0] v);
      return (v >= 16'h0300 && v <= 16'h036F) ||
             (v >= 16'h1AB0 && v <= 16'h1AFF) ||
             (v >= 16'h1DC0 && v <= 16'h1DFF) ||
             (v >= 16'h20D0 && v <= 16'h20FF) ||
             (v >= 16'hFE20 && v <= 16'hFE2F);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dbcd_front.sv -----
// Front end: escape parsing of raw bytes into decoded values and end-of-stream events.
`default_nettype none

module dbcd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_end_of_stream,
   input  wire logic               queue_full,
   output      logic               push,
   output      dbcd_pkg::item_type push_item
);

   logic [2:0]             phase_ff, phase_in;
   dbcd_pkg::esc_kind_type kind_ff, kind_in;
   logic [15:0]            acc_ff, acc_in;
   logic                   stopped_ff, stopped_in;

   logic        accept;
   logic        emit;
   logic [15:0] raw_value;
   logic [15:0] swapped;
   logic [4:0]  digit;
   logic [15:0] feed_acc;
   logic        feed_stopped;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign digit     = dbcd_pkg::hex_digit(req_data_byte);

   always_comb begin
      feed_acc     = acc_ff;
      feed_stopped = stopped_ff;
      if (!stopped_ff) begin
         if (digit[4]) begin
            feed_acc = {acc_ff[11:0], digit[3:0]};
         end else begin
            feed_stopped = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      acc_in     = acc_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      raw_value  = {8'd0, req_data_byte};
      push       = 1'b0;
      push_item.is_eos  = 1'b0;
      push_item.pending = 1'b0;
      if (accept) begin
         if (req_end_of_stream) begin
            push              = 1'b1;
            push_item.is_eos  = 1'b1;
            push_item.pending = (phase_ff != dbcd_pkg::PHASE_IDLE);
            phase_in   = dbcd_pkg::PHASE_IDLE;
            kind_in    = dbcd_pkg::KIND_NONE;
            acc_in     = 16'd0;
            stopped_in = 1'b0;
         end else if (phase_ff == dbcd_pkg::PHASE_IDLE) begin
            if (req_data_byte == dbcd_pkg::CHAR_AT) begin
               phase_in = dbcd_pkg::PHASE_FIRST;
            end else begin
               emit = 1'b1;
            end
         end else if (phase_ff == dbcd_pkg::PHASE_FIRST) begin
            if (req_data_byte == dbcd_pkg::CHAR_AT || req_data_byte == dbcd_pkg::CHAR_STAR ||
                req_data_byte == dbcd_pkg::CHAR_CURRENCY) begin
               emit     = 1'b1;
               phase_in = dbcd_pkg::PHASE_IDLE;
            end else if (req_data_byte == dbcd_pkg::CHAR_AA_LOWER) begin
               emit      = 1'b1;
               raw_value = dbcd_pkg::CP_SMALL_AA;
               phase_in  = dbcd_pkg::PHASE_IDLE;
            end else if (req_data_byte == dbcd_pkg::CHAR_AA_UPPER) begin
               emit      = 1'b1;
               raw_value = dbcd_pkg::CP_CAPITAL_AA;
               phase_in  = dbcd_pkg::PHASE_IDLE;
            end else begin
               phase_in = dbcd_pkg::PHASE_DIGITS;
               if (req_data_byte == dbcd_pkg::CHAR_U) begin
                  kind_in    = dbcd_pkg::KIND_USEQ;
                  acc_in     = 16'd0;
                  stopped_in = 1'b0;
               end else begin
                  kind_in    = dbcd_pkg::KIND_HEX;
                  acc_in     = digit[4] ? {12'd0, digit[3:0]} : 16'd0;
                  stopped_in = !digit[4];
               end
            end
         end else if (kind_ff == dbcd_pkg::KIND_USEQ || kind_ff == dbcd_pkg::KIND_HEX) begin
            if ((kind_ff == dbcd_pkg::KIND_USEQ && phase_ff >= dbcd_pkg::PHASE_USEQ_LAST) ||
                (kind_ff == dbcd_pkg::KIND_HEX && phase_ff >= dbcd_pkg::PHASE_HEX_LAST)) begin
               emit       = 1'b1;
               raw_value  = (kind_ff == dbcd_pkg::KIND_USEQ) ? dbcd_pkg::useq_map(feed_acc)
                                                             : feed_acc;
               phase_in   = dbcd_pkg::PHASE_IDLE;
               kind_in    = dbcd_pkg::KIND_NONE;
               acc_in     = 16'd0;
               stopped_in = 1'b0;
            end else begin
               acc_in     = feed_acc;
               stopped_in = feed_stopped;
               phase_in   = phase_ff + 3'd1;
            end
         end else begin
            phase_in   = dbcd_pkg::PHASE_IDLE;
            kind_in    = dbcd_pkg::KIND_NONE;
            acc_in     = 16'd0;
            stopped_in = 1'b0;
         end
         if (emit) begin
            push = 1'b1;
            if (phase_ff != dbcd_pkg::PHASE_IDLE) begin
               kind_in    = dbcd_pkg::KIND_NONE;
               acc_in     = 16'd0;
               stopped_in = 1'b0;
            end
         end
      end
      swapped           = dbcd_pkg::swap_map(raw_value);
      push_item.value   = push_item.is_eos ? 16'd0 : swapped;
      push_item.is_mark = !push_item.is_eos && dbcd_pkg::is_mark(swapped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= dbcd_pkg::PHASE_IDLE;
         kind_ff    <= dbcd_pkg::KIND_NONE;
         acc_ff     <= 16'd0;
         stopped_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         acc_ff     <= acc_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dbcd_queue.sv -----
// Short register queue between the front and back ends.
`default_nettype none

module dbcd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dbcd_pkg::item_type push_item,
   output      logic               full,
   input  wire logic               pop,
   output      logic               not_empty,
   output      dbcd_pkg::item_type pop_item
);

   localparam int DEPTH = dbcd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dbcd_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dbcd_back.sv -----
// Back end: combining mark stack, reordering and result register.
`default_nettype none

module dbcd_back #(
   parameter int MAX_MARKS = dbcd_pkg::MAX_MARKS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               not_empty,
   input  wire dbcd_pkg::item_type item,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [15:0]        rsp_code_point,
   output      logic               rsp_truncated_error,
   output      logic               rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAX_MARKS + 1);
   localparam int IDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;

   dbcd_pkg::back_state_type state_ff, state_in;
   logic [15:0]      stack_ff [MAX_MARKS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] top_cnt;
   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             out_free;
   logic             room;
   logic             push_mark;
   logic             emit;
   logic [15:0]      emit_cp;
   logic             emit_err;
   logic             emit_last;
   logic             valid_ff, valid_in;
   logic [15:0]      cp_ff;
   logic             err_ff;
   logic             last_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign room     = (count_ff < CNT_W'(MAX_MARKS));
   assign top_cnt  = count_ff - CNT_W'(1);
   assign top_idx  = top_cnt[IDX_W-1:0];
   assign wr_idx   = count_ff[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbcd_pkg::BACK_IDLE: begin
            if (not_empty && !item.is_eos && !(item.is_mark && room) && out_free &&
                count_ff != '0) begin
               state_in = dbcd_pkg::BACK_DRAIN;
            end
         end
         dbcd_pkg::BACK_DRAIN: begin
            if (out_free && count_ff == CNT_W'(1)) begin
               state_in = dbcd_pkg::BACK_IDLE;
            end
         end
         default: state_in = dbcd_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      push_mark = 1'b0;
      emit      = 1'b0;
      emit_cp   = item.value;
      emit_err  = 1'b0;
      emit_last = 1'b0;
      count_in  = count_ff;
      case (state_ff)
         dbcd_pkg::BACK_IDLE: begin
            if (not_empty) begin
               if (item.is_eos) begin
                  if (item.pending || count_ff != '0) begin
                     if (out_free) begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        emit_cp   = 16'd0;
                        emit_err  = 1'b1;
                        emit_last = 1'b1;
                        count_in  = '0;
                     end
                  end else begin
                     pop = 1'b1;
                  end
               end else if (item.is_mark && room) begin
                  pop       = 1'b1;
                  push_mark = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end else if (out_free) begin
                  pop       = 1'b1;
                  emit      = 1'b1;
                  emit_last = (count_ff == '0);
               end
            end
         end
         dbcd_pkg::BACK_DRAIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_cp   = stack_ff[top_idx];
               emit_last = (count_ff == CNT_W'(1));
               count_in  = top_cnt;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   assign valid_in = emit || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (push_mark) begin
         stack_ff[wr_idx] <= item.value;
      end
      if (emit) begin
         cp_ff   <= emit_cp;
         err_ff  <= emit_err;
         last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbcd_pkg::BACK_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_code_point      = cp_ff;
   assign rsp_truncated_error = err_ff;
   assign rsp_last_of_run     = last_ff;

endmodule

`default_nettype wire

// ----- rtl/danmarc_byte_to_codepoint_decoder_unit.sv -----
// Top level of the Danmarc2 byte to code point decoder.
// The block takes one byte per cycle unless stalled and turns it into 16-bit code points.
// The front end parses escapes and maps each decoded value; a two-entry queue passes it
// to the back end, which stacks up to MAX_MARKS leading combining marks and, when the base
// arrives, returns the base followed by the marks in reverse order. A base with n stacked
// marks gives 1 + n results, one per cycle from the single result register unless
// rsp_stall is high; while that burst drains, bytes keep being taken until the queue fills,
// after which req_stall rises. Bytes that produce no result, or a single one, pass at one
// per cycle unless rsp_stall is high. An end-of-stream transaction inside an escape or with
// marks stacked returns one result with truncated_error set and drops the stacked marks.
`default_nettype none

module danmarc_byte_to_codepoint_decoder_unit #(
   parameter int MAX_MARKS = dbcd_pkg::MAX_MARKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_code_point,
   output      logic        rsp_truncated_error,
   output      logic        rsp_last_of_run
);

   logic               queue_full;
   logic               push;
   dbcd_pkg::item_type push_item;
   logic               pop;
   logic               not_empty;
   dbcd_pkg::item_type pop_item;

   dbcd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   dbcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   dbcd_back #(
      .MAX_MARKS (MAX_MARKS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .not_empty           (not_empty),
      .item                (pop_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_point      (rsp_code_point),
      .rsp_truncated_error (rsp_truncated_error),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- tb/tb_danmarc_byte_to_codepoint_decoder_unit.sv -----
// Self-checking testbench for the Danmarc2 byte to code point decoder, with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_danmarc_byte_to_codepoint_decoder_unit;

   typedef struct packed {
      logic [15:0] code_point;
      logic        truncated_error;
      logic        last_of_run;
   } codepoint_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_point;
   logic        rsp_truncated_error;
   logic        rsp_last_of_run;

   // predictor state
   logic [2:0]             esc_phase;
   dbcd_pkg::esc_kind_type esc_kind;
   logic [15:0]            hex_acc;
   logic                   hex_stop;
   logic [15:0]            stacked_marks [dbcd_pkg::MAX_MARKS];
   int                     mark_depth;
   codepoint_result_type   codepoints_due [$];
   codepoint_result_type   head;

   int mismatches = 0;
   int items_sent = 0;
   int hold_left  = 0;
   int rsp_draw   = 0;
   bit req_rush   = 1'b0;
   bit rsp_rush   = 1'b0;

   localparam logic [7:0] SPACING_BYTES [7] = '{8'h5E, 8'h5F, 8'h60, 8'hA8, 8'hAF, 8'hB4,
                                                 8'hB8};
   localparam logic [7:0] USEQ_KEYS [18] = '{8'hA7, 8'hAE, 8'hB0, 8'hB7, 8'hD8, 8'hD9,
                                              8'hDA, 8'hE0, 8'hEB, 8'hEC, 8'hF7, 8'hF8,
                                              8'hF9, 8'hFA, 8'hFC, 8'hFD, 8'hFE, 8'hFF};
   localparam logic [7:0] USEQ_MARK_KEYS [8] = '{8'hE0, 8'hEB, 8'hEC, 8'hF7, 8'hF8, 8'hF9,
                                                  8'hFA, 8'hFC};
   localparam logic [15:0] SPACING_SOURCES [12] = '{16'h005E, 16'h005F, 16'h0060, 16'h00A8,
                                                    16'h00AF, 16'h00B4, 16'h00B8, 16'h02C7,
                                                    16'h02D8, 16'h02DA, 16'h02DB, 16'h02DD};
   localparam logic [15:0] RANGE_EDGES [10] = '{16'h02FF, 16'h0370, 16'h1AAF, 16'h1B00,
                                                16'h1DBF, 16'h1E00, 16'h20CF, 16'h2100,
                                                16'hFE1F, 16'hFE30};

   danmarc_byte_to_codepoint_decoder_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_point      (rsp_code_point),
      .rsp_truncated_error (rsp_truncated_error),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] useq_lookup(input logic [15:0] v);
      if (v[15:8] != 8'h00) return v;
      case (v[7:0])
         8'hA7: return 16'h02B9;
         8'hAE: return 16'h02BC;
         8'hB0: return 16'h02BB;
         8'hB7: return 16'h02BA;
         8'hD8: return 16'h2014;
         8'hD9: return 16'h2191;
         8'hDA: return 16'h2193;
         8'hE0: return 16'h0309;
         8'hEB: return 16'hFE20;
         8'hEC: return 16'hFE21;
         8'hF7: return 16'h0326;
         8'hF8: return 16'h031C;
         8'hF9: return 16'h032E;
         8'hFA: return 16'hFE22;
         8'hFC: return 16'h0308;
         8'hFD: return 16'hF0FD;
         8'hFE: return 16'hF0FE;
         8'hFF: return 16'hF0FF;
         default: return v;
      endcase
   endfunction

   function automatic logic [15:0] spacing_to_combining(input logic [15:0] v);
      case (v)
         16'h005E: return 16'h0302;
         16'h005F: return 16'h0332;
         16'h0060: return 16'h0300;
         16'h00A8: return 16'h0308;
         16'h00AF: return 16'h0304;
         16'h00B4: return 16'h0301;
         16'h00B8: return 16'h0327;
         16'h02C7: return 16'h030C;
         16'h02D8: return 16'h0306;
         16'h02DA: return 16'h030A;
         16'h02DB: return 16'h0328;
         16'h02DD: return 16'h030B;
         default:  return v;
      endcase
   endfunction

   function automatic bit is_combining_mark(input logic [15:0] v);
      return (v >= 16'h0300 && v <= 16'h036F) || (v >= 16'h1AB0 && v <= 16'h1AFF) ||
             (v >= 16'h1DC0 && v <= 16'h1DFF) || (v >= 16'h20D0 && v <= 16'h20FF) ||
             (v >= 16'hFE20 && v <= 16'hFE2F);
   endfunction

   function automatic void emit_codepoint(input logic [15:0] cp, input logic err,
                                          input logic last);
      codepoint_result_type r;
      r.code_point      = cp;
      r.truncated_error = err;
      r.last_of_run     = last;
      codepoints_due.push_back(r);
   endfunction

   function automatic void clear_escape_state();
      esc_phase = dbcd_pkg::PHASE_IDLE;
      esc_kind  = dbcd_pkg::KIND_NONE;
      hex_acc   = 16'h0000;
      hex_stop  = 1'b0;
   endfunction

   function automatic void absorb_digit(input logic [7:0] b);
      logic [3:0] nib;
      if (hex_stop) return;
      if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h57);
      else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h37);
      else begin
         hex_stop = 1'b1;
         return;
      end
      hex_acc = {hex_acc[11:0], nib};
   endfunction

   // stack a leading mark, or release the base and the stacked marks newest first
   function automatic void settle_value(input logic [15:0] raw);
      logic [15:0] v;
      v = (raw != 16'h0000) ? spacing_to_combining(raw) : raw;
      if (mark_depth < dbcd_pkg::MAX_MARKS && is_combining_mark(v)) begin
         stacked_marks[mark_depth] = v;
         mark_depth++;
         return;
      end
      emit_codepoint(v, 1'b0, mark_depth == 0);
      while (mark_depth > 0) begin
         mark_depth--;
         emit_codepoint(stacked_marks[mark_depth], 1'b0, mark_depth == 0);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic [15:0] v;
      if (eos) begin
         if (esc_phase == dbcd_pkg::PHASE_IDLE && mark_depth == 0) return;
         clear_escape_state();
         mark_depth = 0;
         emit_codepoint(16'h0000, 1'b1, 1'b1);
         return;
      end
      if (esc_phase == dbcd_pkg::PHASE_IDLE) begin
         if (b != dbcd_pkg::CHAR_AT) settle_value({8'h00, b});
         else esc_phase = dbcd_pkg::PHASE_FIRST;
         return;
      end
      if (esc_phase == dbcd_pkg::PHASE_FIRST) begin
         if (b == dbcd_pkg::CHAR_AT || b == dbcd_pkg::CHAR_STAR ||
             b == dbcd_pkg::CHAR_CURRENCY) begin
            clear_escape_state();
            settle_value({8'h00, b});
         end else if (b == dbcd_pkg::CHAR_AA_LOWER) begin
            clear_escape_state();
            settle_value(dbcd_pkg::CP_SMALL_AA);
         end else if (b == dbcd_pkg::CHAR_AA_UPPER) begin
            clear_escape_state();
            settle_value(dbcd_pkg::CP_CAPITAL_AA);
         end else begin
            hex_acc   = 16'h0000;
            hex_stop  = 1'b0;
            esc_phase = dbcd_pkg::PHASE_DIGITS;
            if (b == dbcd_pkg::CHAR_U) begin
               esc_kind = dbcd_pkg::KIND_USEQ;
            end else begin
               esc_kind = dbcd_pkg::KIND_HEX;
               absorb_digit(b);
            end
         end
         return;
      end
      if (esc_kind != dbcd_pkg::KIND_USEQ && esc_kind != dbcd_pkg::KIND_HEX) begin
         clear_escape_state();
         return;
      end
      absorb_digit(b);
      if ((esc_kind == dbcd_pkg::KIND_USEQ && esc_phase >= dbcd_pkg::PHASE_USEQ_LAST) ||
          (esc_kind == dbcd_pkg::KIND_HEX && esc_phase >= dbcd_pkg::PHASE_HEX_LAST)) begin
         v = (esc_kind == dbcd_pkg::KIND_USEQ) ? useq_lookup(hex_acc) : hex_acc;
         clear_escape_state();
         settle_value(v);
      end else begin
         esc_phase = esc_phase + 3'd1;
      end
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eos);
      int gap;
      gap = req_rush ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, eos);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h37 : 8'h57) + 8'(n);
   endfunction

   task automatic send_useq(input logic [7:0] key);
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      send_item(dbcd_pkg::CHAR_U, 1'b0);
      send_item(hex_char(key[7:4], 1'($urandom_range(0, 1))), 1'b0);
      send_item(hex_char(key[3:0], 1'($urandom_range(0, 1))), 1'b0);
   endtask

   task automatic send_hex(input logic [15:0] v, input bit corrupt);
      logic [7:0] digits [4];
      int         spoil;
      for (int i = 0; i < 4; i++) begin
         digits[i] = hex_char(v[15 - 4*i -: 4], 1'($urandom_range(0, 1)));
      end
      if (corrupt) begin
         spoil = $urandom_range(0, 3);
         digits[spoil] = 8'($urandom_range(8'h67, 8'hFF));
      end
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      for (int i = 0; i < 4; i++) send_item(digits[i], 1'b0);
   endtask

   function automatic logic [15:0] random_mark_value();
      case ($urandom_range(0, 5))
         0: return 16'h0300 + 16'($urandom_range(0, 16'h6F));
         1: return 16'h1AB0 + 16'($urandom_range(0, 16'h4F));
         2: return 16'h1DC0 + 16'($urandom_range(0, 16'h3F));
         3: return 16'h20D0 + 16'($urandom_range(0, 16'h2F));
         4: return 16'hFE20 + 16'($urandom_range(0, 16'h0F));
         default: return SPACING_SOURCES[$urandom_range(0, 11)];
      endcase
   endfunction

   task automatic send_mark();
      case ($urandom_range(0, 2))
         0: send_item(SPACING_BYTES[$urandom_range(0, 6)], 1'b0);
         1: send_useq(USEQ_MARK_KEYS[$urandom_range(0, 7)]);
         default: send_hex(random_mark_value(), 1'b0);
      endcase
   endtask

   task automatic send_random_piece();
      int         pick;
      logic [7:0] b;
      logic [15:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         b = 8'($urandom_range(0, 255));
         send_item((b == dbcd_pkg::CHAR_AT) ? 8'h41 : b, 1'b0);
      end else if (pick < 40) begin
         send_item(SPACING_BYTES[$urandom_range(0, 6)], 1'b0);
      end else if (pick < 50) begin
         send_item(dbcd_pkg::CHAR_AT, 1'b0);
         case ($urandom_range(0, 4))
            0: send_item(dbcd_pkg::CHAR_AT, 1'b0);
            1: send_item(dbcd_pkg::CHAR_STAR, 1'b0);
            2: send_item(dbcd_pkg::CHAR_CURRENCY, 1'b0);
            3: send_item(dbcd_pkg::CHAR_AA_LOWER, 1'b0);
            default: send_item(dbcd_pkg::CHAR_AA_UPPER, 1'b0);
         endcase
      end else if (pick < 62) begin
         send_useq(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : USEQ_KEYS[$urandom_range(0, 17)]);
      end else if (pick < 82) begin
         case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 16'hFFFF));
            1: v = RANGE_EDGES[$urandom_range(0, 9)];
            2: v = 16'h0000;
            default: v = random_mark_value();
         endcase
         send_hex(v, $urandom_range(0, 5) == 0);
      end else if (pick < 91) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 95) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         // cut an escape short
         send_item(dbcd_pkg::CHAR_AT, 1'b0);
         if ($urandom_range(0, 1)) send_item(dbcd_pkg::CHAR_U, 1'b0);
         repeat ($urandom_range(0, 2)) send_item(hex_char(4'($urandom_range(0, 15)), 1'b1),
                                                  1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic test_short_escapes();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("@@@*");
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      send_item(dbcd_pkg::CHAR_CURRENCY, 1'b0);
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      send_item(dbcd_pkg::CHAR_AA_LOWER, 1'b0);
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      send_item(dbcd_pkg::CHAR_AA_UPPER, 1'b0);
   endtask

   task automatic test_hex_escapes();
      send_text("@Ueb");
      send_text("@2c7g");
      send_text("@Uz5");
   endtask

   task automatic test_mark_stacking();
      repeat (dbcd_pkg::MAX_MARKS) send_item(8'h5E, 1'b0);
      send_item(8'h60, 1'b0);
   endtask

   task automatic test_end_of_stream();
      send_item(8'h00, 1'b1);
      send_item(dbcd_pkg::CHAR_AT, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h5E, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_stream();
      int marks;
      while (items_sent < 465) begin
         req_rush = ($urandom_range(0, 3) == 0);
         rsp_rush = ($urandom_range(0, 3) == 0);
         marks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, dbcd_pkg::MAX_MARKS + 2)
                                             : 0;
         repeat (marks) send_mark();
         send_random_piece();
      end
      req_valid <= 1'b0;
   endtask

   // result side: hold off for a drawn number of cycles after each transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_stall) begin
         if (hold_left <= 1) rsp_stall <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (rsp_valid) begin
         rsp_draw = rsp_rush ? 0 : $urandom_range(0, 19);
         hold_left <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (codepoints_due.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %h/%b/%b", $time,
                     rsp_code_point, rsp_truncated_error, rsp_last_of_run);
            mismatches++;
         end else begin
            head = codepoints_due.pop_front();
            if (rsp_code_point !== head.code_point) begin
               $display("%0t: code_point expected %h actual %h", $time, head.code_point,
                        rsp_code_point);
               mismatches++;
            end
            if (rsp_truncated_error !== head.truncated_error) begin
               $display("%0t: truncated_error expected %b actual %b", $time,
                        head.truncated_error, rsp_truncated_error);
               mismatches++;
            end
            if (rsp_last_of_run !== head.last_of_run) begin
               $display("%0t: last_of_run expected %b actual %b", $time, head.last_of_run,
                        rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_danmarc_byte_to_codepoint_decoder_unit NOT OK");
      $finish;
   end

   initial begin
      clear_escape_state();
      mark_depth = 0;
      foreach (stacked_marks[i]) stacked_marks[i] = 16'h0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_escapes();
      test_hex_escapes();
      test_mark_stacking();
      test_end_of_stream();
      test_random_stream();
      while (codepoints_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_danmarc_byte_to_codepoint_decoder_unit OK");
      end else begin
         $display("tb_danmarc_byte_to_codepoint_decoder_unit NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
